FILE: rtl/tlfs_pkg.sv
// Shared types and constants of the three-level feedback scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tlfs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_JOB_ID_BITS = 8;
  localparam int NUM_LEVELS      = 3;
  localparam int SLICE_BITS      = 4;
  localparam int LEVEL_BITS      = 2;

  localparam logic [SLICE_BITS-1:0] RESET_SLICES = 4'd2;

  // internal level codes, highest priority first
  localparam logic [LEVEL_BITS-1:0] LVL_HI  = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_MID = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_LO  = 2'd2;

  // requested-level codes on the input
  localparam logic [LEVEL_BITS-1:0] REQ_HI  = 2'd1;
  localparam logic [LEVEL_BITS-1:0] REQ_MID = 2'd2;

  typedef enum logic [1:0] {
    PTR_NONE,
    PTR_PUSH,
    PTR_POP
  } ptr_op_e;

  typedef struct packed {
    ptr_op_e                op;
    logic [LEVEL_BITS-1:0]  lvl;
  } ptr_req_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0] full;
    logic [NUM_LEVELS-1:0] empty;
  } ptr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tlfs_queue_mem.sv
// Queue storage for all three levels: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tlfs_queue_mem #(
  parameter int QUEUE_DEPTH = tlfs_pkg::DEF_QUEUE_DEPTH,
  parameter int ENTRY_BITS  = tlfs_pkg::DEF_JOB_ID_BITS + tlfs_pkg::SLICE_BITS + 1,
  parameter int PTR_BITS    = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                              clk_i,
  input  wire logic                              wr_en_i,
  input  wire logic [tlfs_pkg::LEVEL_BITS-1:0]   wr_lvl_i,
  input  wire logic [PTR_BITS-1:0]               wr_ptr_i,
  input  wire logic [ENTRY_BITS-1:0]             wr_data_i,
  input  wire logic                              rd_en_i,
  input  wire logic [tlfs_pkg::LEVEL_BITS-1:0]   rd_lvl_i,
  input  wire logic [PTR_BITS-1:0]               rd_ptr_i,
  output logic      [ENTRY_BITS-1:0]             rd_data_o
);
  import tlfs_pkg::*;

  logic [ENTRY_BITS-1:0] mem_q [NUM_LEVELS][QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_lvl_i][wr_ptr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_lvl_i][rd_ptr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlfs_ptr_unit.sv
// Head, tail and fill count of each level, with one shared push/pop unit.
`timescale 1ns / 1ps
`default_nettype none

module tlfs_ptr_unit #(
  parameter int QUEUE_DEPTH = tlfs_pkg::DEF_QUEUE_DEPTH,
  parameter int PTR_BITS    = $clog2(QUEUE_DEPTH),
  parameter int FILL_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tlfs_pkg::ptr_req_t  req_i,
  output tlfs_pkg::ptr_stat_t      stat_o,
  output logic [PTR_BITS-1:0]      head_o,
  output logic [PTR_BITS-1:0]      tail_o
);
  import tlfs_pkg::*;

  logic [PTR_BITS-1:0]  head_q [NUM_LEVELS];
  logic [PTR_BITS-1:0]  tail_q [NUM_LEVELS];
  logic [FILL_BITS-1:0] fill_q [NUM_LEVELS];

  logic do_push, do_pop;

  function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      stat_o.full[i]  = (fill_q[i] == FILL_BITS'(QUEUE_DEPTH));
      stat_o.empty[i] = (fill_q[i] == '0);
    end
  end

  assign head_o  = head_q[req_i.lvl];
  assign tail_o  = tail_q[req_i.lvl];
  assign do_push = (req_i.op == PTR_PUSH) && !stat_o.full[req_i.lvl];
  assign do_pop  = (req_i.op == PTR_POP) && !stat_o.empty[req_i.lvl];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (do_push) begin
      tail_q[req_i.lvl] <= wrap_inc(tail_q[req_i.lvl]);
      fill_q[req_i.lvl] <= fill_q[req_i.lvl] + 1'b1;
    end else if (do_pop) begin
      head_q[req_i.lvl] <= wrap_inc(head_q[req_i.lvl]);
      fill_q[req_i.lvl] <= fill_q[req_i.lvl] - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/three_level_feedback_scheduler.sv
// Top level of the three-level feedback scheduler: slot sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Three-level feedback scheduler. Each input beat is one scheduling slot and
// yields exactly one output beat. A slot first requeues the job dispatched in
// the previous slot (unless reported finished), bumping its slice count and
// moving it between levels once the count reaches slices_q; then the optional
// new job is pushed to its level; then the head of the highest non-empty level
// is dispatched. A push into a full level drops that job and sets dropped. A
// slot steps through accept, requeue, admit, pick and result; result waits on a
// stalled output, and no new slot is taken meanwhile. This order is set by the
// single push/pop port of the pointer unit, the single write port of the queue
// memory and its registered read. No clearing pass is needed after reset: the
// pointers reset to empty and only written queue entries are ever read. The
// configuration port is always ready and must be written only while idle.

module three_level_feedback_scheduler #(
  parameter int QUEUE_DEPTH = tlfs_pkg::DEF_QUEUE_DEPTH,
  parameter int JOB_ID_BITS = tlfs_pkg::DEF_JOB_ID_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // slot input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               admit_valid_i,
  input  wire logic [7:0]                         new_job_i,
  input  wire logic [tlfs_pkg::LEVEL_BITS-1:0]    new_level_i,
  input  wire logic                               last_finished_i,
  // dispatch output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    dispatch_valid_o,
  output logic      [7:0]                         dispatch_job_o,
  output logic      [tlfs_pkg::LEVEL_BITS-1:0]    dispatch_level_o,
  output logic                                    dropped_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tlfs_pkg::SLICE_BITS-1:0]    cfg_data_i
);
  import tlfs_pkg::*;

  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_BITS = JOB_ID_BITS + SLICE_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_ADMIT,
    ST_PICK,
    ST_OUT
  } state_e;

  state_e                  state_q;
  logic [SLICE_BITS-1:0]   slices_q;

  // latched slot fields
  logic                    admit_q;
  logic [JOB_ID_BITS-1:0]  job_q;
  logic [LEVEL_BITS-1:0]   admit_lvl_q;
  logic                    fin_q;
  logic                    drop_q;

  // job running in the current slot
  logic                    run_valid_q;
  logic [JOB_ID_BITS-1:0]  run_job_q;
  logic [SLICE_BITS-1:0]   run_cnt_q;
  logic                    run_up_q;
  logic [LEVEL_BITS-1:0]   run_lvl_q;

  // dispatch decision from the pick step
  logic                    disp_q;
  logic [LEVEL_BITS-1:0]   pick_lvl_q;

  ptr_req_t                ptr_req;
  ptr_stat_t               ptr_stat;
  logic [PTR_BITS-1:0]     head, tail;

  logic                    mem_wr_en, mem_rd_en;
  logic [ENTRY_BITS-1:0]   mem_wr_data, mem_rd_data;

  logic [JOB_ID_BITS+7:0]  job_in_wide;
  logic [JOB_ID_BITS+7:0]  job_out_wide;
  logic [JOB_ID_BITS-1:0]  rd_job;
  logic [SLICE_BITS-1:0]   rd_cnt;
  logic                    rd_up;

  // requeue computation
  logic [SLICE_BITS-1:0]   cnt_inc, rq_cnt;
  logic                    rq_up;
  logic [LEVEL_BITS-1:0]   rq_lvl;
  logic                    requeue;

  logic [LEVEL_BITS-1:0]   pick_lvl;
  logic                    pick_hit;
  logic [LEVEL_BITS-1:0]   admit_lvl_in;
  logic                    out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_o || !out_stall_i;

  // identifiers keep JOB_ID_BITS bits; the port shows the low 8
  assign job_in_wide  = {{JOB_ID_BITS{1'b0}}, new_job_i};
  assign job_out_wide = {8'b0, rd_job};
  assign rd_job       = mem_rd_data[ENTRY_BITS-1 -: JOB_ID_BITS];
  assign rd_cnt       = mem_rd_data[SLICE_BITS:1];
  assign rd_up        = mem_rd_data[0];

  always_comb begin
    case (new_level_i)
      REQ_HI:  admit_lvl_in = LVL_HI;
      REQ_MID: admit_lvl_in = LVL_MID;
      default: admit_lvl_in = LVL_LO;
    endcase
  end

  // slice accounting and level move of the previous job
  always_comb begin
    cnt_inc = run_cnt_q + 1'b1;
    rq_cnt  = cnt_inc;
    rq_up   = run_up_q;
    rq_lvl  = run_lvl_q;
    if (cnt_inc >= slices_q) begin
      rq_cnt = '0;
      case (run_lvl_q)
        LVL_HI: begin
          rq_up  = 1'b0;
          rq_lvl = LVL_MID;
        end
        LVL_MID: begin
          rq_lvl = run_up_q ? LVL_HI : LVL_LO;
        end
        default: begin
          rq_up  = 1'b1;
          rq_lvl = LVL_MID;
        end
      endcase
    end
  end

  assign requeue = run_valid_q && !fin_q;

  // highest non-empty level
  always_comb begin
    pick_hit = 1'b1;
    if (!ptr_stat.empty[LVL_HI]) begin
      pick_lvl = LVL_HI;
    end else if (!ptr_stat.empty[LVL_MID]) begin
      pick_lvl = LVL_MID;
    end else if (!ptr_stat.empty[LVL_LO]) begin
      pick_lvl = LVL_LO;
    end else begin
      pick_lvl = LVL_LO;
      pick_hit = 1'b0;
    end
  end

  // drive the shared pointer unit and the queue memory
  always_comb begin
    ptr_req.op  = PTR_NONE;
    ptr_req.lvl = LVL_HI;
    mem_wr_en   = 1'b0;
    mem_wr_data = {run_job_q, rq_cnt, rq_up};
    mem_rd_en   = 1'b0;
    case (state_q)
      ST_SETTLE: begin
        if (requeue) begin
          ptr_req.op  = PTR_PUSH;
          ptr_req.lvl = rq_lvl;
          mem_wr_en   = !ptr_stat.full[rq_lvl];
        end
      end
      ST_ADMIT: begin
        mem_wr_data = {job_q, {SLICE_BITS{1'b0}}, 1'b0};
        if (admit_q) begin
          ptr_req.op  = PTR_PUSH;
          ptr_req.lvl = admit_lvl_q;
          mem_wr_en   = !ptr_stat.full[admit_lvl_q];
        end
      end
      ST_PICK: begin
        ptr_req.lvl = pick_lvl;
        if (pick_hit) begin
          ptr_req.op = PTR_POP;
          mem_rd_en  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      slices_q         <= RESET_SLICES;
      run_valid_q      <= 1'b0;
      out_valid_o      <= 1'b0;
      admit_q          <= 1'b0;
      fin_q            <= 1'b0;
      drop_q           <= 1'b0;
      disp_q           <= 1'b0;
      job_q            <= '0;
      admit_lvl_q      <= LVL_HI;
      pick_lvl_q       <= LVL_HI;
      run_job_q        <= '0;
      run_cnt_q        <= '0;
      run_up_q         <= 1'b0;
      run_lvl_q        <= LVL_HI;
      dispatch_valid_o <= 1'b0;
      dispatch_job_o   <= '0;
      dispatch_level_o <= '0;
      dropped_o        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        slices_q <= cfg_data_i;
      end
      // a beat leaving in ST_OUT is replaced by the new one below
      if (out_valid_o && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            admit_q     <= admit_valid_i;
            job_q       <= job_in_wide[JOB_ID_BITS-1:0];
            admit_lvl_q <= admit_lvl_in;
            fin_q       <= last_finished_i;
            drop_q      <= 1'b0;
            state_q     <= ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          if (requeue && ptr_stat.full[rq_lvl]) begin
            drop_q <= 1'b1;
          end
          state_q <= ST_ADMIT;
        end
        ST_ADMIT: begin
          if (admit_q && ptr_stat.full[admit_lvl_q]) begin
            drop_q <= 1'b1;
          end
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          disp_q     <= pick_hit;
          pick_lvl_q <= pick_lvl;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          // read data is valid here; wait for room in the output register
          if (out_free) begin
            out_valid_o      <= 1'b1;
            dispatch_valid_o <= disp_q;
            dispatch_job_o   <= disp_q ? job_out_wide[7:0] : 8'd0;
            dispatch_level_o <= disp_q ? pick_lvl_q + 1'b1 : '0;
            dropped_o        <= drop_q;
            run_valid_q      <= disp_q;
            run_job_q        <= rd_job;
            run_cnt_q        <= rd_cnt;
            run_up_q         <= rd_up;
            run_lvl_q        <= pick_lvl_q;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  tlfs_ptr_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_BITS    (PTR_BITS),
    .FILL_BITS   (FILL_BITS)
  ) u_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ptr_req),
    .stat_o (ptr_stat),
    .head_o (head),
    .tail_o (tail)
  );

  tlfs_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS),
    .PTR_BITS    (PTR_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_lvl_i  (ptr_req.lvl),
    .wr_ptr_i  (tail),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_lvl_i  (ptr_req.lvl),
    .rd_ptr_i  (head),
    .rd_data_o (mem_rd_data)
  );

endmodule

`default_nettype wire

FILE: tb/three_level_feedback_scheduler_tb.sv
// Self-checking testbench for the three-level feedback scheduler.
`timescale 1ns / 1ps

module three_level_feedback_scheduler_tb;
  import tlfs_pkg::*;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;

  // One queued job: id, slices used at its level, heading up.
  typedef struct packed {
    logic [7:0]            job;
    logic [SLICE_BITS-1:0] slices;
    logic                  up;
  } job_entry_t;

  // One dispatch beat as seen on the output channel.
  typedef struct packed {
    logic                  dv;
    logic [7:0]            job;
    logic [LEVEL_BITS-1:0] lvl;
    logic                  dropped;
  } dispatch_t;

  // Mirror of the scheduler state plus the dispatches still owed.
  class mlfq_tracker;
    job_entry_t            lq_mem  [NUM_LEVELS][QDEPTH];
    int unsigned           lq_head [NUM_LEVELS];
    int unsigned           lq_tail [NUM_LEVELS];
    int unsigned           lq_fill [NUM_LEVELS];
    job_entry_t            cur_job;
    logic [LEVEL_BITS-1:0] cur_lvl;
    bit                    busy;
    logic [SLICE_BITS-1:0] threshold;
    dispatch_t             owed [int unsigned];
    int unsigned           owed_wr;
    int unsigned           owed_rd;
    int unsigned           failures;

    function new();
      busy      = 1'b0;
      cur_lvl   = LVL_HI;
      threshold = RESET_SLICES;
      failures  = 0;
      owed_wr   = 0;
      owed_rd   = 0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        lq_head[l] = 0;
        lq_tail[l] = 0;
        lq_fill[l] = 0;
      end
    endfunction

    function void set_threshold(logic [SLICE_BITS-1:0] v);
      threshold = v;
    endfunction

    function int unsigned pending();
      return owed_wr - owed_rd;
    endfunction

    function bit push_job(logic [LEVEL_BITS-1:0] l, job_entry_t e);
      if (lq_fill[l] >= QDEPTH) return 1'b0;
      lq_mem[l][lq_tail[l]] = e;
      lq_tail[l] = (lq_tail[l] + 1) % QDEPTH;
      lq_fill[l]++;
      return 1'b1;
    endfunction

    function job_entry_t take_job(int unsigned l);
      job_entry_t e;
      e = lq_mem[l][lq_head[l]];
      lq_head[l] = (lq_head[l] + 1) % QDEPTH;
      lq_fill[l]--;
      return e;
    endfunction

    // Called once per accepted slot beat.
    function void note_slot(logic admit, logic [7:0] job, logic [LEVEL_BITS-1:0] req,
                            logic fin);
      job_entry_t            e;
      logic [LEVEL_BITS-1:0] l;
      logic                  drop;
      dispatch_t             d;
      int                    i;
      drop = 1'b0;
      // settle last slot's job: bump slices, maybe change level, requeue
      if (busy && !fin) begin
        e = cur_job;
        l = cur_lvl;
        e.slices = e.slices + 1'b1;
        if (e.slices >= threshold) begin
          e.slices = '0;
          case (l)
            LVL_HI: begin
              e.up = 1'b0;
              l    = LVL_MID;
            end
            LVL_MID: begin
              l = e.up ? LVL_HI : LVL_LO;
            end
            default: begin
              e.up = 1'b1;
              l    = LVL_MID;
            end
          endcase
        end
        if (!push_job(l, e)) drop = 1'b1;
      end
      busy = 1'b0;
      if (admit) begin
        e.job    = job;
        e.slices = '0;
        e.up     = 1'b0;
        l = (req == REQ_HI) ? LVL_HI : (req == REQ_MID) ? LVL_MID : LVL_LO;
        if (!push_job(l, e)) drop = 1'b1;
      end
      d = '0;
      for (i = 0; i < NUM_LEVELS; i++) begin
        if (!d.dv && lq_fill[i] != 0) begin
          cur_job = take_job(i);
          cur_lvl = LEVEL_BITS'(i);
          busy    = 1'b1;
          d.dv    = 1'b1;
          d.job   = cur_job.job;
          d.lvl   = LEVEL_BITS'(i + 1);
        end
      end
      d.dropped = drop;
      owed[owed_wr] = d;
      owed_wr++;
    endfunction

    // Called once per accepted dispatch beat; fields shown as valid/job/level/dropped.
    function void check_dispatch(dispatch_t got);
      dispatch_t want;
      if (owed_wr == owed_rd) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected beat %0d/%02h/%0d/%0d",
                   $realtime, got.dv, got.job, got.lvl, got.dropped);
        return;
      end
      want = owed[owed_rd];
      owed.delete(owed_rd);
      owed_rd++;
      if (got.dv !== want.dv || got.job !== want.job || got.lvl !== want.lvl ||
          got.dropped !== want.dropped) begin
        failures++;
        if (failures <= 10)
          $display("%0t: exp %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                   $realtime, want.dv, want.job, want.lvl, want.dropped,
                   got.dv, got.job, got.lvl, got.dropped);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  admit_valid_i;
  logic [7:0]            new_job_i;
  logic [LEVEL_BITS-1:0] new_level_i;
  logic                  last_finished_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  dispatch_valid_o;
  logic [7:0]            dispatch_job_o;
  logic [LEVEL_BITS-1:0] dispatch_level_o;
  logic                  dropped_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [SLICE_BITS-1:0] cfg_data_i;

  // Shared between the slot driver and the dispatch sink.
  bit          quiet_stretch;   // no idling on either side while set
  int unsigned hold_reqs;       // bumped by the driver to ask for a long output hold

  mlfq_tracker tracker;

  three_level_feedback_scheduler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .admit_valid_i    (admit_valid_i),
    .new_job_i        (new_job_i),
    .new_level_i      (new_level_i),
    .last_finished_i  (last_finished_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dispatch_valid_o (dispatch_valid_o),
    .dispatch_job_o   (dispatch_job_o),
    .dispatch_level_o (dispatch_level_o),
    .dropped_o        (dropped_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop; several times the slowest legal run (~1300 slots, sink stalls and
  // the long hold included).
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Dispatch sink: checks every accepted beat and drives out_stall_i.
  // Random stalls ~16%, none during a quiet stretch, and a long hold whenever
  // the driver asks for one, so the block backs up into its input.
  initial begin : dispatch_sink
    int unsigned hold_seen;
    int unsigned hold_left;
    dispatch_t   got;
    hold_seen = 0;
    hold_left = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.dv      = dispatch_valid_o;
        got.job     = dispatch_job_o;
        got.lvl     = dispatch_level_o;
        got.dropped = dropped_o;
        tracker.check_dispatch(got);
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet_stretch) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 16);
      end
    end
  end

  // Offer one slot beat and hold it until accepted. The valid is lowered after
  // acceptance only for a random gap or when the caller says the burst ends.
  task automatic offer_slot(input logic admit, input logic [7:0] job,
                            input logic [LEVEL_BITS-1:0] req, input logic fin,
                            input bit burst_end);
    int unsigned gap;
    gap = 0;
    in_valid_i      <= 1'b1;
    admit_valid_i   <= admit;
    new_job_i       <= job;
    new_level_i     <= req;
    last_finished_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_slot(admit, job, req, fin);
    if (!quiet_stretch && $urandom_range(99) < 16) gap = $urandom_range(1, 8);
    if (burst_end || gap != 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_threshold(input logic [SLICE_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.set_threshold(v);
  endtask

  // Drain, let the pipeline settle, retune the threshold.
  task automatic retune(input logic [SLICE_BITS-1:0] v);
    wait_drained();
    repeat (8) @(posedge clk_i);
    write_threshold(v);
  endtask

  // A burst of random slots. admit_pct / fin_pct shape the load: low finish
  // rates keep jobs cycling through the levels and fill the FIFOs to drops,
  // high finish rates drain them to empty dispatches. pause_at >= 0 makes the
  // driver stop after that slot until every dispatch has come back.
  task automatic random_burst(input int unsigned n, input int unsigned admit_pct,
                              input int unsigned fin_pct, input int pause_at);
    int i;
    for (i = 0; i < n; i++) begin
      offer_slot($urandom_range(99) < admit_pct, 8'($urandom_range(255)),
                 LEVEL_BITS'($urandom_range(3)), $urandom_range(99) < fin_pct,
                 (i == n - 1) || (i == pause_at));
      if (i == pause_at) wait_drained();
    end
  endtask

  initial begin : slot_driver
    int i;
    tracker = new();
    quiet_stretch   <= 1'b0;
    hold_reqs       <= 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    admit_valid_i   <= 1'b0;
    new_job_i       <= '0;
    new_level_i     <= '0;
    last_finished_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed slots at the reset threshold.
    offer_slot(1'b0, 8'h00, 2'd0, 1'b1, 1'b0);   // nothing running: finish ignored, empty dispatch
    offer_slot(1'b1, 8'hFF, 2'd1, 1'b0, 1'b0);   // level 1 admit
    offer_slot(1'b1, 8'h00, 2'd0, 1'b0, 1'b0);   // request code 0 -> lowest level
    offer_slot(1'b1, 8'h55, 2'd2, 1'b0, 1'b0);   // level 2; level-1 job moves down
    offer_slot(1'b1, 8'hAA, 2'd3, 1'b1, 1'b0);   // request code 3 -> lowest level
    for (i = 0; i < 9; i++)                      // nobody finishes: jobs migrate up and down
      offer_slot(1'b0, 8'($urandom_range(255)), LEVEL_BITS'($urandom_range(3)), 1'b0, 1'b0);
    for (i = 0; i < 7; i++)                      // everyone finishes: drain to empty
      offer_slot(1'b0, 8'($urandom_range(255)), LEVEL_BITS'($urandom_range(3)), 1'b1, 1'b0);
    offer_slot(1'b1, 8'h80, 2'd1, 1'b1, 1'b0);
    offer_slot(1'b1, 8'h7F, 2'd2, 1'b0, 1'b1);

    // Largest threshold, heavy admits, rare finishes: FIFOs fill and drop.
    retune(4'd15);
    random_burst(160, 80, 5, -1);

    // Threshold lowered under jobs holding higher slice counts.
    retune(4'd1);
    random_burst(150, 40, 20, -1);

    // Threshold zero: move on every expired slice.
    retune(4'd0);
    random_burst(150, 50, 30, -1);

    // Long output hold while the driver keeps offering slots.
    retune(4'd4);
    hold_reqs <= hold_reqs + 1;
    random_burst(200, 60, 10, -1);

    // Mostly finishing; the driver stops halfway until all dispatches are back.
    retune(4'($urandom_range(1, 15)));
    random_burst(180, 30, 60, 90);

    // No idling on either side.
    retune(4'd2);
    quiet_stretch <= 1'b1;
    random_burst(150, 55, 15, -1);
    quiet_stretch <= 1'b0;

    retune(4'($urandom_range(15)));
    random_burst(240, $urandom_range(20, 90), $urandom_range(0, 50), -1);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
